>>> src/size_keyed_id_pool_defines.svh
// assertion macros used by the id pool datapath
`ifndef SIZE_KEYED_ID_POOL_DEFINES_SVH
`define SIZE_KEYED_ID_POOL_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, held off during reset
`define SKIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id pool check failed");
// next-cycle implication, held off during reset
`define SKIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id pool check failed");
`else
`define SKIP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKIP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/skip_pkg.sv
// types and codes shared by the id pool controller and datapath
`default_nettype none
package skip_pkg;

    // slot mode codes, code three reads as empty
    localparam logic [1:0] MODE_EMPTY = 2'd0;
    localparam logic [1:0] MODE_OUT   = 2'd1;
    localparam logic [1:0] MODE_AVAIL = 2'd2;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_NEW       = 3'd1,
        ST_POOLED    = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_FULL      = 3'd5,
        ST_EXHAUSTED = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN1,
        S_PICK,
        S_SCAN2,
        S_FINISH
    } t_state;

    // which slot a finishing request writes
    typedef enum logic [1:0] {
        WR_NONE,
        WR_AT_AVAIL,
        WR_AT_OUT,
        WR_AT_EMPTY
    } t_wr;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] ident;
        logic [15:0] bytes;
    } t_slot;

    typedef struct packed {
        logic       clear_en;
        logic       load;
        logic       scan_start;
        logic       key2;
        logic       finish;
        t_wr        wr;
        logic [1:0] wr_mode;
        t_status    status;
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic scan_done;
        logic is_ret;
        logic avail_found;
        logic out_found;
        logic empty_found;
        logic cnt_over;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> src/skip_dp.sv
// datapath: slot memory, scan unit, id counter and result register
`default_nettype none
`include "size_keyed_id_pool_defines.svh"
module skip_dp #(
    parameter int POOL_SLOTS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire skip_pkg::t_cmd i_cmd,
    output skip_pkg::t_stat    o_stat,
    input  wire logic          i_cfg_valid,
    input  wire logic [15:0]   i_cfg_start_id,
    input  wire logic          i_command,
    input  wire logic [15:0]   i_req_size,
    input  wire logic [15:0]   i_ret_id,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [15:0]        o_result_id,
    output logic [2:0]         o_status
);
    import skip_pkg::*;

    localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

    t_slot mem [POOL_SLOTS];

    logic [IDX_W-1:0] r_addr;
    logic             r_scan_active;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    t_slot            r_rd_word;

    logic        r_cmd_ret;
    logic [15:0] r_key_bytes;
    logic [15:0] r_key_ident;
    logic [16:0] r_counter;

    logic             r_avail_found;
    logic [IDX_W-1:0] r_avail_idx;
    logic [15:0]      r_avail_ident;
    logic             r_out_found;
    logic [IDX_W-1:0] r_out_idx;
    logic [15:0]      r_out_bytes;
    logic             r_empty_found;
    logic [IDX_W-1:0] r_empty_idx;

    logic        r_out_valid;
    logic [15:0] r_result_id;
    t_status     r_status;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_slot            wr_word;
    logic             hit_avail;
    logic             hit_out;
    logic             hit_empty;

    // address walk shared by the clearing pass and the scans
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr        <= '0;
            r_scan_active <= 1'b0;
            r_rd_valid    <= 1'b0;
        end else begin
            r_rd_valid <= r_scan_active;
            if (i_cmd.clear_en) begin
                r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
            end else if (i_cmd.scan_start) begin
                r_addr        <= '0;
                r_scan_active <= 1'b1;
            end else if (r_scan_active) begin
                if (r_addr == LAST_IDX) begin
                    r_scan_active <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // write port source select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_word = '{mode: MODE_EMPTY, ident: 16'd0, bytes: 16'd0};
        if (i_cmd.clear_en) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish) begin
            case (i_cmd.wr)
                WR_AT_AVAIL: begin
                    wr_en   = 1'b1;
                    wr_addr = r_avail_idx;
                    wr_word = '{mode: i_cmd.wr_mode, ident: r_avail_ident,
                                bytes: r_key_bytes};
                end
                WR_AT_OUT: begin
                    wr_en   = 1'b1;
                    wr_addr = r_out_idx;
                    wr_word = '{mode: i_cmd.wr_mode, ident: r_key_ident,
                                bytes: r_out_bytes};
                end
                WR_AT_EMPTY: begin
                    wr_en   = 1'b1;
                    wr_addr = r_empty_idx;
                    wr_word = '{mode: i_cmd.wr_mode, ident: r_counter[15:0],
                                bytes: r_key_bytes};
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (r_scan_active) begin
            r_rd_word <= mem[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    // compare the slot just read against the keys
    always_comb begin
        hit_avail = (r_rd_word.mode == MODE_AVAIL) && (r_rd_word.bytes == r_key_bytes);
        hit_out   = (r_rd_word.mode == MODE_OUT) && (r_rd_word.ident == r_key_ident);
        hit_empty = (r_rd_word.mode != MODE_OUT) && (r_rd_word.mode != MODE_AVAIL);
    end

    // lowest matching slot of each kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avail_found <= 1'b0;
            r_out_found   <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_avail_found <= 1'b0;
            r_out_found   <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (r_rd_valid) begin
            if (hit_avail && !r_avail_found) begin
                r_avail_found <= 1'b1;
                r_avail_idx   <= r_rd_idx;
                r_avail_ident <= r_rd_word.ident;
            end
            if (hit_out && !r_out_found) begin
                r_out_found <= 1'b1;
                r_out_idx   <= r_rd_idx;
                r_out_bytes <= r_rd_word.bytes;
            end
            if (hit_empty && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_rd_idx;
            end
        end
    end

    // request beat capture and second-pass key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd_ret   <= i_command;
            r_key_bytes <= i_req_size;
            r_key_ident <= i_command ? i_ret_id : r_counter[15:0];
        end else if (i_cmd.key2) begin
            if (r_cmd_ret) begin
                r_key_bytes <= r_out_bytes;
            end else begin
                r_key_ident <= r_avail_ident;
            end
        end
    end

    // fresh id counter, advanced by each fresh grant and otherwise loaded by a config beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (i_cmd.finish && (i_cmd.status == ST_NEW)) begin
            r_counter <= r_counter + 17'd1;
        end else if (i_cfg_valid) begin
            r_counter <= {1'b0, i_cfg_start_id};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            case (i_cmd.status)
                ST_REUSED: r_result_id <= r_avail_ident;
                ST_NEW:    r_result_id <= r_counter[15:0];
                default:   r_result_id <= 16'd0;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_id = r_result_id;
    assign o_status    = r_status;

    // status back to the controller
    always_comb begin
        o_stat.addr_last   = (r_addr == LAST_IDX);
        o_stat.scan_done   = r_rd_valid && (r_rd_idx == LAST_IDX);
        o_stat.is_ret      = r_cmd_ret;
        o_stat.avail_found = r_avail_found;
        o_stat.out_found   = r_out_found;
        o_stat.empty_found = r_empty_found;
        o_stat.cnt_over    = r_counter[16];
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    // a fresh grant always advances the counter by one
    `SKIP_ASSERT_NXT(a_new_bumps_counter, i_clk, i_rst_n,
        i_cmd.finish && (i_cmd.status == ST_NEW), r_counter == $past(r_counter) + 17'd1)
    // table writes never land while a scan is reading
    `SKIP_ASSERT_IMP(a_write_outside_scan, i_clk, i_rst_n,
        i_cmd.finish && (i_cmd.wr != WR_NONE), !r_scan_active && !r_rd_valid)
    // a reuse needs an available slot of the size
    `SKIP_ASSERT_IMP(a_reuse_has_slot, i_clk, i_rst_n,
        i_cmd.finish && (i_cmd.status == ST_REUSED), r_avail_found)

endmodule
`default_nettype wire

>>> src/skip_ctrl.sv
// controller: clearing pass, scan sequencing and the per-request decision
`default_nettype none
module skip_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire skip_pkg::t_stat i_stat,
    output skip_pkg::t_cmd      o_cmd
);
    import skip_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.wr      = WR_NONE;
        o_cmd.wr_mode = MODE_EMPTY;
        o_cmd.status  = ST_UNKNOWN;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (i_stat.scan_done) begin
                    n_state = S_PICK;
                end
            end
            // second pass when the first one found the slot of interest
            S_PICK: begin
                if (i_stat.is_ret ? i_stat.out_found : i_stat.avail_found) begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.key2       = 1'b1;
                    n_state          = S_SCAN2;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN2: begin
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (i_stat.is_ret) begin
                        if (!i_stat.out_found) begin
                            o_cmd.status = ST_UNKNOWN;
                        end else if (i_stat.avail_found) begin
                            o_cmd.status  = ST_DROPPED;
                            o_cmd.wr      = WR_AT_OUT;
                            o_cmd.wr_mode = MODE_EMPTY;
                        end else begin
                            o_cmd.status  = ST_POOLED;
                            o_cmd.wr      = WR_AT_OUT;
                            o_cmd.wr_mode = MODE_AVAIL;
                        end
                    end else if (i_stat.avail_found) begin
                        // reuse a pooled id: mark its slot out, or drop the slot if the id is held elsewhere
                        o_cmd.status  = ST_REUSED;
                        o_cmd.wr      = WR_AT_AVAIL;
                        o_cmd.wr_mode = i_stat.out_found ? MODE_EMPTY : MODE_OUT;
                    end else if (i_stat.cnt_over) begin
                        o_cmd.status = ST_EXHAUSTED;
                    end else if (i_stat.out_found) begin
                        o_cmd.status = ST_NEW;
                    end else if (i_stat.empty_found) begin
                        o_cmd.status  = ST_NEW;
                        o_cmd.wr      = WR_AT_EMPTY;
                        o_cmd.wr_mode = MODE_OUT;
                    end else begin
                        o_cmd.status = ST_FULL;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/size_keyed_id_pool.sv
// top level of the size keyed id pool
//
//  channel   direction  ports                                      beat
//  cfg       in         i_cfg_valid / o_cfg_ready, i_cfg_start_id  one start id write
//  request   in         i_in_valid / o_in_ready, i_command,        one get or return
//                       i_req_size, i_ret_id
//  result    out        o_out_valid / i_out_ready, o_result_id,    one id and status
//                       o_status
//
// one request at a time; each pass walks the slot memory over its single read port,
//   one slot per cycle, and a second pass follows when the first finds the slot of interest
// after reset a clearing pass empties the table; no request is taken meanwhile,
//   config beats are taken at any time
// the result sits in an output register; a stalled result holds the next request
//   in its finish state until the register frees
`default_nettype none
module size_keyed_id_pool #(
    parameter int POOL_SLOTS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_start_id,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [15:0] i_req_size,
    input  wire logic [15:0] i_ret_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_result_id,
    output logic [2:0]       o_status
);
    import skip_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // always ready; a start id beat is lost if a fresh grant advances the counter in that cycle
    assign o_cfg_ready = 1'b1;

    skip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    skip_dp #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_start_id (i_cfg_start_id),
        .i_command      (i_command),
        .i_req_size     (i_req_size),
        .i_ret_id       (i_ret_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_id    (o_result_id),
        .o_status       (o_status)
    );

endmodule
`default_nettype wire
